@@ hdl/nms_pkg.sv @@
`default_nettype none
package nms_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   // register and counter widths
   localparam int WID_W       = 11;
   localparam int HGT_W       = 13;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

   // direction values in degrees
   localparam logic [7:0] DEG_0   = 8'd0;
   localparam logic [7:0] DEG_45  = 8'd45;
   localparam logic [7:0] DEG_90  = 8'd90;
   localparam logic [7:0] DEG_135 = 8'd135;

   typedef logic [7:0] pix_type;

   typedef enum logic [2:0] {
      DIR_0     = 3'd0,
      DIR_45    = 3'd1,
      DIR_90    = 3'd2,
      DIR_135   = 3'd3,
      DIR_BAD   = 3'd4,
      DIR_EMPTY = 3'd7
   } dir_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // [row][column]: row 0 is the line above the centre, column 0 the pixel to its left
   typedef pix_type [2:0][2:0] window_type;

   typedef struct packed {
      logic         left;
      logic         right;
      logic         top;
      logic         bottom;
      logic         last;
      dir_code_type code;
   } centre_type;

   function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] raw);
      logic [WID_W-1:0] w;
      w = raw;
      if (raw < WID_W'(2)) w = WID_W'(2);
      else if (raw > WID_W'(MAX_WIDTH)) w = WID_W'(MAX_WIDTH);
      return w;
   endfunction

   function automatic logic [HGT_W-1:0] eff_height(input logic [HGT_W-1:0] raw);
      logic [HGT_W-1:0] h;
      h = raw;
      if (raw < HGT_W'(2)) h = HGT_W'(2);
      else if (raw > HGT_W'(MAX_HEIGHT)) h = HGT_W'(MAX_HEIGHT);
      return h;
   endfunction

endpackage
`default_nettype wire

@@ hdl/nms_window.sv @@
`default_nettype none
module nms_window (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            restart,
   input  wire logic                            step,
   input  wire logic                            fresh,
   input  wire logic [7:0]                      req_magnitude,
   input  wire logic [7:0]                      req_direction,
   input  wire logic                            req_pad,
   input  wire logic [nms_pkg::WID_W-1:0]       width,
   output nms_pkg::window_type                  win,
   output nms_pkg::dir_code_type                old_code
);

   typedef struct packed {
      nms_pkg::pix_type      mag;
      nms_pkg::dir_code_type code;
      nms_pkg::pix_type      older;
   } lb_word_type;

   lb_word_type mem [nms_pkg::MAX_WIDTH];
   lb_word_type rd_ff;

   logic [nms_pkg::COL_W-1:0] ptr_ff, ptr_in, prev_ptr_ff;
   nms_pkg::pix_type          near_ff [3];
   nms_pkg::pix_type          mid_ff  [2];
   nms_pkg::pix_type          far_ff  [2];
   nms_pkg::dir_code_type     code_ff, code_in;
   nms_pkg::pix_type          mag_in;

   always_comb begin
      if (req_pad) begin
         code_in = nms_pkg::DIR_EMPTY;
      end else begin
         case (req_direction)
            nms_pkg::DEG_0:   code_in = nms_pkg::DIR_0;
            nms_pkg::DEG_45:  code_in = nms_pkg::DIR_45;
            nms_pkg::DEG_90:  code_in = nms_pkg::DIR_90;
            nms_pkg::DEG_135: code_in = nms_pkg::DIR_135;
            default:          code_in = nms_pkg::DIR_BAD;
         endcase
      end
      mag_in = req_pad ? 8'd0 : req_magnitude;
   end

   // line pointer wraps at the active width
   assign ptr_in = ((nms_pkg::WID_W'({1'b0, ptr_ff}) + nms_pkg::WID_W'(1)) >= width)
                   ? '0 : ptr_ff + nms_pkg::COL_W'(1);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         ptr_ff <= '0;
      end else if (step) begin
         ptr_ff <= ptr_in;
      end
   end

   // read the word stored one line ago; write back the previous word one step late
   always_ff @(posedge clock) begin
      if (step) begin
         rd_ff <= mem[ptr_ff];
      end
      if (step && fresh) begin
         mem[prev_ptr_ff] <= '{mag: near_ff[2], code: code_ff, older: rd_ff.mag};
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         prev_ptr_ff <= ptr_ff;
         code_ff     <= code_in;
         near_ff[2]  <= mag_in;
         near_ff[1]  <= near_ff[2];
         near_ff[0]  <= near_ff[1];
         mid_ff[1]   <= rd_ff.mag;
         mid_ff[0]   <= mid_ff[1];
         far_ff[1]   <= rd_ff.older;
         far_ff[0]   <= far_ff[1];
      end
   end

   always_comb begin
      win[2][2] = near_ff[2];
      win[2][1] = near_ff[1];
      win[2][0] = near_ff[0];
      win[1][2] = rd_ff.mag;
      win[1][1] = mid_ff[1];
      win[1][0] = mid_ff[0];
      win[0][2] = rd_ff.older;
      win[0][1] = far_ff[1];
      win[0][0] = far_ff[0];
   end

   assign old_code = rd_ff.code;

endmodule
`default_nettype wire

@@ hdl/nms_track.sv @@
`default_nettype none
module nms_track (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            restart,
   input  wire logic                            accept,
   input  wire logic                            req_pad,
   input  wire logic [nms_pkg::WID_W-1:0]       width,
   input  wire logic [nms_pkg::HGT_W-1:0]       height,
   input  wire nms_pkg::dir_code_type           old_code,
   output logic                                 step,
   output logic                                 emit,
   output logic                                 fresh,
   output nms_pkg::centre_type                  centre
);

   logic [nms_pkg::COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [nms_pkg::ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [nms_pkg::WID_W-1:0] lead_ff, lead_in, fill_ff, fill_in;
   logic                      drop, primed, in_eol, in_eof, out_eol, out_eof;
   nms_pkg::centre_type       centre_ff;

   // drop a pad unless the frame is complete and results are pending
   assign drop   = req_pad && ((lead_ff == '0) || (in_col_ff != '0) || (in_row_ff != '0));
   assign step   = accept && !drop;
   assign primed = (fill_ff == (width + nms_pkg::WID_W'(1)));
   assign emit   = step && primed && (old_code != nms_pkg::DIR_EMPTY);
   assign fresh  = (fill_ff != '0);

   assign in_eol  = (nms_pkg::WID_W'({1'b0, in_col_ff}) + nms_pkg::WID_W'(1)) >= width;
   assign in_eof  = (nms_pkg::HGT_W'({1'b0, in_row_ff}) + nms_pkg::HGT_W'(1)) >= height;
   assign out_eol = (nms_pkg::WID_W'({1'b0, out_col_ff}) + nms_pkg::WID_W'(1)) >= width;
   assign out_eof = (nms_pkg::HGT_W'({1'b0, out_row_ff}) + nms_pkg::HGT_W'(1)) >= height;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lead_in    = lead_ff;
      fill_in    = fill_ff;
      if (step) begin
         if (!primed) fill_in = fill_ff + nms_pkg::WID_W'(1);
         if (!req_pad) begin
            lead_in = lead_ff + nms_pkg::WID_W'(1);
            if (in_eol) begin
               in_col_in = '0;
               in_row_in = in_eof ? '0 : in_row_ff + nms_pkg::ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + nms_pkg::COL_W'(1);
            end
         end
         if (emit) begin
            if (lead_in != '0) lead_in = lead_in - nms_pkg::WID_W'(1);
            if (out_eol) begin
               out_col_in = '0;
               out_row_in = out_eof ? '0 : out_row_ff + nms_pkg::ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + nms_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lead_ff    <= '0;
         fill_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lead_ff    <= lead_in;
         fill_ff    <= fill_in;
      end
   end

   // position flags of the centre pixel that this step brings into the window
   always_ff @(posedge clock) begin
      if (emit) begin
         centre_ff.left   <= (out_col_ff == '0);
         centre_ff.right  <= out_eol;
         centre_ff.top    <= (out_row_ff == '0);
         centre_ff.bottom <= out_eof;
         centre_ff.last   <= out_eol && out_eof;
         centre_ff.code   <= old_code;
      end
   end

   assign centre = centre_ff;

endmodule
`default_nettype wire

@@ hdl/nms_pick.sv @@
`default_nettype none
module nms_pick (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire nms_pkg::window_type   win,
   input  wire nms_pkg::centre_type   centre,
   output logic [7:0]                 rsp_suppressed_magnitude,
   output logic                       rsp_bad_direction,
   output logic                       rsp_last_of_frame
);

   localparam logic [1:0] IDX_LOW  = 2'd0;
   localparam logic [1:0] IDX_MID  = 2'd1;
   localparam logic [1:0] IDX_HIGH = 2'd2;

   typedef struct packed {
      logic [1:0] ax;
      logic [1:0] ay;
      logic [1:0] bx;
      logic [1:0] by;
   } pair_type;

   pair_type         pr;
   logic             bad;
   logic [1:0]       ax, ay, bx, by;
   nms_pkg::pix_type ctr, na, nb, result;
   logic [7:0]       mag_ff;
   logic             bad_ff, last_ff;

   // mirror an offset that would leave the frame, without repeating the edge
   function automatic logic [1:0] refl(input logic [1:0] idx, input logic lo, input logic hi);
      logic [1:0] r;
      r = idx;
      if (idx == IDX_LOW && lo) r = IDX_HIGH;
      else if (idx == IDX_HIGH && hi) r = IDX_LOW;
      return r;
   endfunction

   always_comb begin
      bad = 1'b0;
      case (centre.code)
         nms_pkg::DIR_0:   pr = '{ax: IDX_HIGH, ay: IDX_MID,  bx: IDX_LOW,  by: IDX_MID};
         nms_pkg::DIR_45:  pr = '{ax: IDX_HIGH, ay: IDX_LOW,  bx: IDX_LOW,  by: IDX_HIGH};
         nms_pkg::DIR_90:  pr = '{ax: IDX_MID,  ay: IDX_LOW,  bx: IDX_MID,  by: IDX_HIGH};
         nms_pkg::DIR_135: pr = '{ax: IDX_LOW,  ay: IDX_LOW,  bx: IDX_HIGH, by: IDX_HIGH};
         default: begin
            pr  = '{ax: IDX_MID, ay: IDX_MID, bx: IDX_MID, by: IDX_MID};
            bad = 1'b1;
         end
      endcase
      ax  = refl(pr.ax, centre.left, centre.right);
      bx  = refl(pr.bx, centre.left, centre.right);
      ay  = refl(pr.ay, centre.top, centre.bottom);
      by  = refl(pr.by, centre.top, centre.bottom);
      ctr = win[IDX_MID][IDX_MID];
      na  = win[ay][ax];
      nb  = win[by][bx];
      if (bad || (ctr < na) || (ctr < nb)) result = 8'd0;
      else result = ctr;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff  <= result;
         bad_ff  <= bad;
         last_ff <= centre.last;
      end
   end

   assign rsp_suppressed_magnitude = mag_ff;
   assign rsp_bad_direction        = bad_ff;
   assign rsp_last_of_frame        = last_ff;

endmodule
`default_nettype wire

@@ hdl/non_maximum_suppression_3x3.sv @@
// Result timing: a pixel's result is computed once width+1 further items (pixels or flush pads
//   that are not dropped) are accepted, width being frame_width clamped to 2..1024; it
//   then reaches rsp through the compare stage register and the output register.
// Throughput: one item per cycle unless rsp stalls; per step one buffer read, one deferred write.
// Reset (synchronous, active high) clears counters, valids and pointers and sets 640x480;
//   line buffer contents are not cleared. A width or height write restarts the stream likewise.
`default_nettype none
module non_maximum_suppression_3x3 (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_magnitude,
   input  wire logic [7:0]                          req_direction,
   input  wire logic                                req_pad,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [7:0]                               rsp_suppressed_magnitude,
   output logic                                     rsp_bad_direction,
   output logic                                     rsp_last_of_frame,
   input  wire logic                                csr_write_enable,
   input  wire logic [nms_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [nms_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic [nms_pkg::WID_W-1:0] frame_width_ff, width;
   logic [nms_pkg::HGT_W-1:0] frame_height_ff, height;
   logic                      restart, accept, step, emit, fresh, s2_free, move;
   logic                      s1_vld_ff, s1_vld_in, rsp_valid_ff, rsp_valid_in;
   nms_pkg::window_type       win;
   nms_pkg::dir_code_type     old_code;
   nms_pkg::centre_type       centre;

   assign restart = csr_write_enable && ((csr_index == nms_pkg::CSR_FRAME_WIDTH) ||
                                         (csr_index == nms_pkg::CSR_FRAME_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= nms_pkg::WIDTH_RESET;
         frame_height_ff <= nms_pkg::HEIGHT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == nms_pkg::CSR_FRAME_WIDTH) begin
            frame_width_ff <= csr_write_data[nms_pkg::WID_W-1:0];
         end
         if (csr_index == nms_pkg::CSR_FRAME_HEIGHT) begin
            frame_height_ff <= csr_write_data[nms_pkg::HGT_W-1:0];
         end
      end
   end

   assign width  = nms_pkg::eff_width(frame_width_ff);
   assign height = nms_pkg::eff_height(frame_height_ff);

   // compare stage holds one word; the output register parts it from the consumer
   assign s2_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || s2_free;
   assign accept    = req_valid && req_ready;
   assign move      = s1_vld_ff && s2_free;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (step) s1_vld_in = emit;
      else if (move) s1_vld_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (move) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   nms_track u_track (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .accept   (accept),
      .req_pad  (req_pad),
      .width    (width),
      .height   (height),
      .old_code (old_code),
      .step     (step),
      .emit     (emit),
      .fresh    (fresh),
      .centre   (centre)
   );

   nms_window u_window (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .step          (step),
      .fresh         (fresh),
      .req_magnitude (req_magnitude),
      .req_direction (req_direction),
      .req_pad       (req_pad),
      .width         (width),
      .win           (win),
      .old_code      (old_code)
   );

   nms_pick u_pick (
      .clock                    (clock),
      .load                     (move),
      .win                      (win),
      .centre                   (centre),
      .rsp_suppressed_magnitude (rsp_suppressed_magnitude),
      .rsp_bad_direction        (rsp_bad_direction),
      .rsp_last_of_frame        (rsp_last_of_frame)
   );

endmodule
`default_nettype wire

@@ hdl/nms_checker.sv @@
`default_nettype none
module nms_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [7:0]                        rsp_suppressed_magnitude,
   input wire logic                              rsp_bad_direction,
   input wire logic                              rsp_last_of_frame,
   input wire logic                              csr_write_enable,
   input wire logic [nms_pkg::CSR_INDEX_W-1:0]   csr_index
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_suppressed_magnitude) &&
                                  $stable(rsp_bad_direction) && $stable(rsp_last_of_frame))
      else $error("result word changed while stalled");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_direction |-> rsp_suppressed_magnitude == 8'd0)
      else $error("bad direction with nonzero magnitude");

   // input side must not wait while the output register is free
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // drop pending results on a register write
   a_csr_flush: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable && ((csr_index == nms_pkg::CSR_FRAME_WIDTH) ||
                           (csr_index == nms_pkg::CSR_FRAME_HEIGHT)) |=> !rsp_valid)
      else $error("result valid after register write");

endmodule

bind non_maximum_suppression_3x3 nms_checker u_nms_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_ready                (req_ready),
   .rsp_valid                (rsp_valid),
   .rsp_ready                (rsp_ready),
   .rsp_suppressed_magnitude (rsp_suppressed_magnitude),
   .rsp_bad_direction        (rsp_bad_direction),
   .rsp_last_of_frame        (rsp_last_of_frame),
   .csr_write_enable         (csr_write_enable),
   .csr_index                (csr_index)
);
`default_nettype wire

@@ sim/non_maximum_suppression_3x3_tb.sv @@
`timescale 1ns / 1ps
module non_maximum_suppression_3x3_tb;

   localparam int HIST_DEPTH     = 2 * nms_pkg::MAX_WIDTH + 3;
   localparam int LINE_DEPTH     = nms_pkg::MAX_WIDTH + 1;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PIXELS  = 30;
   localparam int RESET_PIXELS   = 643;
   localparam int CLAMP_PIXELS   = 20;

   typedef struct packed {
      logic [7:0] magnitude;
      logic       bad;
      logic       frame_end;
   } nms_word_type;

   bit                              clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [7:0]                      req_magnitude;
   logic [7:0]                      req_direction;
   logic                            req_pad;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [7:0]                      rsp_suppressed_magnitude;
   logic                            rsp_bad_direction;
   logic                            rsp_last_of_frame;
   logic                            csr_write_enable;
   logic [nms_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [nms_pkg::CSR_DATA_W-1:0]  csr_write_data;

   // predictor state
   logic [7:0]                mag_hist [HIST_DEPTH];
   nms_pkg::dir_code_type     dir_line [LINE_DEPTH];
   logic [nms_pkg::WID_W-1:0] width_reg;
   logic [nms_pkg::HGT_W-1:0] height_reg;
   int                        hist_ptr;
   int                        line_ptr;
   int                        in_col;
   int                        in_row;
   int                        out_col;
   int                        out_row;
   int                        pending_px;
   nms_word_type              expected_pixels [$];

   int error_count = 0;
   int idle_cycles = 0;
   int pixel_total = 0;
   int send_gap_pct;
   int recv_stall_pct;

   non_maximum_suppression_3x3 u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_magnitude            (req_magnitude),
      .req_direction            (req_direction),
      .req_pad                  (req_pad),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_suppressed_magnitude (rsp_suppressed_magnitude),
      .rsp_bad_direction        (rsp_bad_direction),
      .rsp_last_of_frame        (rsp_last_of_frame),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int clamp_size(input int raw, input int hi);
      if (raw < 2) return 2;
      if (raw > hi) return hi;
      return raw;
   endfunction

   function automatic int cur_width();
      return clamp_size(int'(width_reg), nms_pkg::MAX_WIDTH);
   endfunction

   function automatic int cur_height();
      return clamp_size(int'(height_reg), nms_pkg::MAX_HEIGHT);
   endfunction

   function automatic void restart_stream();
      foreach (mag_hist[i]) mag_hist[i] = '0;
      foreach (dir_line[i]) dir_line[i] = nms_pkg::DIR_EMPTY;
      hist_ptr   = 0;
      line_ptr   = 0;
      in_col     = 0;
      in_row     = 0;
      out_col    = 0;
      out_row    = 0;
      pending_px = 0;
   endfunction

   // reflect without repeating the edge pixel
   function automatic int mirror(input int v, input int hi);
      if (v < 0) return -v;
      if (v > hi) return 2 * hi - v;
      return v;
   endfunction

   // magnitude d words after the centre; the centre sits w+1 words back
   function automatic logic [7:0] hist_at(input int d, input int w);
      int k;
      k = w + 1 - d;
      if (k < 0) k = 0;
      if (k > 2 * w + 2) k = 2 * w + 2;
      return mag_hist[(hist_ptr + HIST_DEPTH - k) % HIST_DEPTH];
   endfunction

   function automatic logic [7:0] neighbour_mag(input int dx, input int dy,
                                                input int w, input int h);
      int nx;
      int ny;
      nx = mirror(out_col + dx, w - 1);
      ny = mirror(out_row + dy, h - 1);
      return hist_at((ny - out_row) * w + (nx - out_col), w);
   endfunction

   function automatic void predict_suppression(input logic [7:0] mag_in,
                                               input logic [7:0] dir_in,
                                               input logic pad_in);
      int                    w;
      int                    h;
      logic [7:0]            mag;
      nms_pkg::dir_code_type code;
      nms_pkg::dir_code_type old;
      logic [7:0]            centre;
      logic [7:0]            n1;
      logic [7:0]            n2;
      int                    dx1;
      int                    dy1;
      int                    dx2;
      int                    dy2;
      nms_word_type          word;
      w   = cur_width();
      h   = cur_height();
      mag = mag_in;
      if (pad_in) begin
         // drop pads with nothing pending or before the frame's last pixel
         if (pending_px == 0 || in_col != 0 || in_row != 0) return;
         code = nms_pkg::DIR_EMPTY;
         mag  = '0;
      end else begin
         case (dir_in)
            nms_pkg::DEG_0:   code = nms_pkg::DIR_0;
            nms_pkg::DEG_45:  code = nms_pkg::DIR_45;
            nms_pkg::DEG_90:  code = nms_pkg::DIR_90;
            nms_pkg::DEG_135: code = nms_pkg::DIR_135;
            default:          code = nms_pkg::DIR_BAD;
         endcase
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
         end else begin
            in_col++;
         end
         pending_px++;
      end

      mag_hist[hist_ptr] = mag;
      old                = dir_line[line_ptr];
      dir_line[line_ptr] = code;
      line_ptr           = (line_ptr + 1 >= w + 1) ? 0 : line_ptr + 1;

      if (old == nms_pkg::DIR_EMPTY) begin
         hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
         return;
      end
      if (pending_px > 0) pending_px--;

      centre         = hist_at(0, w);
      word.magnitude = '0;
      word.bad       = 1'b1;
      if (old != nms_pkg::DIR_BAD) begin
         case (old)
            nms_pkg::DIR_0: begin
               dx1 = 1;  dy1 = 0;  dx2 = -1; dy2 = 0;
            end
            nms_pkg::DIR_45: begin
               dx1 = 1;  dy1 = -1; dx2 = -1; dy2 = 1;
            end
            nms_pkg::DIR_90: begin
               dx1 = 0;  dy1 = -1; dx2 = 0;  dy2 = 1;
            end
            default: begin
               dx1 = -1; dy1 = -1; dx2 = 1;  dy2 = 1;
            end
         endcase
         n1             = neighbour_mag(dx1, dy1, w, h);
         n2             = neighbour_mag(dx2, dy2, w, h);
         word.magnitude = (centre < n1 || centre < n2) ? 8'd0 : centre;
         word.bad       = 1'b0;
      end
      word.frame_end = (out_row + 1 >= h && out_col + 1 >= w);
      expected_pixels.push_back(word);

      if (out_col + 1 >= w) begin
         out_col = 0;
         out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
      end else begin
         out_col++;
      end
      hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_words
      nms_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("word with nothing expected", rsp_suppressed_magnitude, 8'd0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_suppressed_magnitude !== want.magnitude)
               report_mismatch("suppressed_magnitude", rsp_suppressed_magnitude,
                               want.magnitude);
            if (rsp_bad_direction !== want.bad)
               report_mismatch("bad_direction", 8'(rsp_bad_direction), 8'(want.bad));
            if (rsp_last_of_frame !== want.frame_end)
               report_mismatch("last_of_frame", 8'(rsp_last_of_frame),
                               8'(want.frame_end));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("non_maximum_suppression_3x3: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // small values half the time so that ties with neighbours are common
   function automatic logic [7:0] random_mag();
      if ($urandom_range(1)) return 8'($urandom_range(3));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] random_dir();
      int unsigned r;
      r = $urandom_range(19);
      if (r < 17) begin
         case (r % 4)
            0:       return nms_pkg::DEG_0;
            1:       return nms_pkg::DEG_45;
            2:       return nms_pkg::DEG_90;
            default: return nms_pkg::DEG_135;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic send_word(input logic [7:0] mag, input logic [7:0] dir, input logic pad);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_magnitude <= mag;
      req_direction <= dir;
      req_pad       <= pad;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_suppression(mag, dir, pad);
      if (!pad) pixel_total++;
      @(negedge clock);
   endtask

   task automatic send_pad();
      send_word(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
   endtask

   task automatic flush_frame();
      repeat (cur_width() + 1) send_pad();
   endtask

   task automatic stream_frame(input int pixels, input bit stray_pads);
      for (int i = 0; i < pixels; i++) begin
         if (stray_pads && $urandom_range(15) == 0) send_pad();
         send_word(random_mag(), random_dir(), 1'b0);
      end
   endtask

   // hold the sender until every expected word is out
   task automatic wait_for_results(input bit settle);
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (expected_pixels.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input nms_pkg::csr_index_type idx, input int value);
      wait_for_results(1'b1);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= nms_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == nms_pkg::CSR_FRAME_WIDTH) width_reg = nms_pkg::WID_W'(value);
      else height_reg = nms_pkg::HGT_W'(value);
      restart_stream();
   endtask

   task automatic set_geometry(input int w, input int h);
      csr_write(nms_pkg::CSR_FRAME_WIDTH, w);
      csr_write(nms_pkg::CSR_FRAME_HEIGHT, h);
   endtask

   task automatic random_geometry();
      int w;
      int h;
      case ($urandom_range(7))
         0:       w = $urandom_range(1);
         1:       w = $urandom_range(48, 30);
         default: w = $urandom_range(12, 2);
      endcase
      if ($urandom_range(7) == 0) h = $urandom_range(1);
      else if (w > 12) h = $urandom_range(3, 2);
      else h = $urandom_range(6, 2);
      set_geometry(w, h);
   endtask

   // rows of 640 after reset; the stream is cut off by the next register write
   task automatic test_reset_geometry();
      stream_frame(RESET_PIXELS, 1'b0);
   endtask

   task automatic test_directed_frames();
      // bits above the 11-bit width register must be dropped: width is 3
      set_geometry('h1803, 2);
      send_word(8'd255, nms_pkg::DEG_0,   1'b0);
      send_word(8'd0,   nms_pkg::DEG_45,  1'b0);
      send_pad();
      send_word(8'd128, nms_pkg::DEG_90,  1'b0);
      send_word(8'd200, nms_pkg::DEG_135, 1'b0);
      send_word(8'd255, 8'd1,             1'b0);
      send_word(8'd0,   8'd255,           1'b0);
      flush_frame();
      send_pad();
      // equal neighbours must not suppress the centre
      send_word(8'd7, nms_pkg::DEG_0,   1'b0);
      send_word(8'd7, nms_pkg::DEG_0,   1'b0);
      send_word(8'd7, nms_pkg::DEG_90,  1'b0);
      send_word(8'd8, nms_pkg::DEG_45,  1'b0);
      send_word(8'd7, nms_pkg::DEG_135, 1'b0);
      send_word(8'd6, nms_pkg::DEG_90,  1'b0);
      // next frame pushes the previous one out without pads
      send_word(8'd3, nms_pkg::DEG_45,  1'b0);
      send_word(8'd9, nms_pkg::DEG_135, 1'b0);
      send_word(8'd1, nms_pkg::DEG_0,   1'b0);
      send_pad();
      send_word(8'd2, nms_pkg::DEG_90,  1'b0);
      send_word(8'd5, 8'd44,            1'b0);
      send_word(8'd4, nms_pkg::DEG_0,   1'b0);
      flush_frame();
   endtask

   task automatic test_random_frames(input int gap, input int stall);
      int start;
      int pixels;
      int remaining;
      bit first;
      send_gap_pct   = gap;
      recv_stall_pct = stall;
      start          = pixel_total;
      first          = 1'b1;
      random_geometry();
      while (pixel_total - start < RANDOM_PIXELS) begin
         if ($urandom_range(3) == 0) random_geometry();
         pixels = cur_width() * cur_height();
         // now and then cut a frame short so that the next one starts misaligned
         if ($urandom_range(7) == 0) pixels = $urandom_range(pixels, 1);
         remaining = RANDOM_PIXELS - (pixel_total - start);
         if (pixels > remaining) pixels = remaining;
         stream_frame(pixels, $urandom_range(3) == 0);
         if ($urandom_range(2) != 0) flush_frame();
         if ($urandom_range(5) == 0) send_pad();
         if (first) wait_for_results(1'b0);
         first = 1'b0;
      end
   endtask

   task automatic test_clamped_sizes();
      set_geometry(0, 1);
      stream_frame(4, 1'b0);
      flush_frame();
      set_geometry(1, 0);
      stream_frame(4, 1'b0);
      flush_frame();
      set_geometry(2047, 2);
      stream_frame(CLAMP_PIXELS, 1'b0);
      set_geometry(2, 8191);
      stream_frame(CLAMP_PIXELS, 1'b0);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_magnitude    = '0;
      req_direction    = '0;
      req_pad          = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      send_gap_pct     = 13;
      recv_stall_pct   = 61;
      width_reg        = nms_pkg::WIDTH_RESET;
      height_reg       = nms_pkg::HEIGHT_RESET;
      restart_stream();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_reset_geometry();
      test_directed_frames();
      test_random_frames(13, 61);
      test_random_frames(61, 13);
      test_random_frames(0, 0);
      test_clamped_sizes();

      wait_for_results(1'b1);
      if (error_count == 0) begin
         $display("non_maximum_suppression_3x3: match");
      end else begin
         $display("non_maximum_suppression_3x3: mismatch");
      end
      $finish;
   end

endmodule
